/* src/mtc_pkg.sv */
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and constants for the MIDI time code decoder
// Status codes, sysex header bytes, time code record and millisecond scaling.
// ----------------------------------------------------------------------------
package mtc_pkg;

   // Message status bytes
   localparam logic [7:0] STATUS_QUARTER_FRAME = 8'hF1;
   localparam logic [7:0] STATUS_SYSEX         = 8'hF0;

   // Full-frame sysex framing
   localparam logic [7:0] FULL_FRAME_LENGTH = 8'd10;
   localparam logic [7:0] SYSEX_UNIVERSAL   = 8'h7F;
   localparam logic [7:0] SYSEX_ALL_DEVICES = 8'h7F;
   localparam logic [7:0] SYSEX_SUB_ID_MTC  = 8'h01;
   localparam logic [7:0] SYSEX_FULL_FRAME  = 8'h01;
   localparam logic [7:0] SYSEX_END         = 8'hF7;

   // Quarter-frame pieces needed for one complete code
   localparam logic [3:0] PIECES_PER_CODE = 4'd8;
   localparam logic [3:0] PIECE_COUNT_MAX = 4'hF;

   // Configuration register indexes
   localparam logic CSR_GAP_LIMIT    = 1'b0;
   localparam logic CSR_FRAME_ADJUST = 1'b1;

   // Register reset values
   localparam logic [15:0] GAP_LIMIT_RESET    = 16'd100;
   localparam logic [1:0]  FRAME_ADJUST_RESET = 2'd2;
   localparam logic [1:0]  RATE_RESET         = 2'd1;   // 25 fps

   typedef enum logic [1:0] {
      DIR_UNKNOWN  = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } dir_type;

   typedef enum logic [3:0] {
      PIECE_FRAMES_LO  = 4'd0,
      PIECE_FRAMES_HI  = 4'd1,
      PIECE_SECONDS_LO = 4'd2,
      PIECE_SECONDS_HI = 4'd3,
      PIECE_MINUTES_LO = 4'd4,
      PIECE_MINUTES_HI = 4'd5,
      PIECE_HOURS_LO   = 4'd6,
      PIECE_HOURS_HI   = 4'd7
   } piece_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic [6:0] frames;
      logic [1:0] rate;
   } mtc_time_type;

   typedef struct packed {
      logic         done;
      mtc_time_type tc;
   } mtc_qf_result_type;

   localparam int HEAD_WIDTH = 27;

   // Milliseconds per time unit
   localparam logic [26:0] HOUR_MS   = 27'd3600000;
   localparam logic [26:0] MINUTE_MS = 27'd60000;
   localparam logic [26:0] SECOND_MS = 27'd1000;

   // Frame to millisecond scaling: ms = (frames * FRAME_MS_K[rate]) >> FRAME_MS_SHIFT.
   // Each constant is the ceiling of (ms per frame) * 2^24; for frame counts up to
   // 127 the rounding error stays below the smallest nonzero fractional step.
   localparam int FRAME_MS_SHIFT = 24;
   localparam logic [29:0] FRAME_MS_K [4] = '{
      30'd699050667,    // 24 fps
      30'd671088640,    // 25 fps
      30'd559800334,    // 29.97 fps
      30'd559240534     // 30 fps
   };

endpackage

/* src/midi_timecode_decoder_unit.sv */
// ----------------------------------------------------------------------------
// midi_timecode_decoder_unit: MIDI time code decoder
// Decodes quarter-frame and full-frame messages into time and head position.
// ----------------------------------------------------------------------------
// One MIDI message is taken per transfer on the req_ channel and exactly one
// result per message leaves on the rsp_ channel, in order. A message goes
// through an input register, one pass of decode and head-position logic, and
// a result register, so the unit takes a new message every cycle when the
// output is not stalled. The input register and the result register each
// hold one message, so while the result is stalled one more message can
// transfer into the input register; after that req_stall stays high until
// the result is taken. Quarter-frame messages (F1) are gathered piece by
// piece; a code completes at piece 7 when running forward or at piece 0
// when running backward, and the frame count then gets frame_adjust frames
// added. A full-frame sysex message of length 10 sets the time directly.
// head_ms is the truncated position in milliseconds. code_running is 1 when
// gap_ms does not exceed gap_limit_ms. The user writes configuration through
// csr_write only while no message is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module midi_timecode_decoder_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_msg_length,
   input  logic [7:0]  req_byte_one,
   input  logic [7:0]  req_byte_two,
   input  logic [7:0]  req_byte_three,
   input  logic [7:0]  req_byte_four,
   input  logic [7:0]  req_byte_five,
   input  logic [7:0]  req_byte_six,
   input  logic [7:0]  req_byte_seven,
   input  logic [7:0]  req_byte_eight,
   input  logic [7:0]  req_byte_nine,
   input  logic [15:0] req_gap_ms,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_time_updated,
   output logic        rsp_code_running,
   output logic [4:0]  rsp_out_hours,
   output logic [6:0]  rsp_out_minutes,
   output logic [6:0]  rsp_out_seconds,
   output logic [6:0]  rsp_out_frames,
   output logic [1:0]  rsp_out_rate,
   output logic [26:0] rsp_head_ms
);

   // configuration
   logic [15:0] gap_limit_ff;
   logic [1:0]  frame_adjust_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  status_ff, length_ff;
   logic [7:0]  b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff, b7_ff, b8_ff, b9_ff;
   logic [15:0] gap_ff;

   // result register; the latched time doubles as decoder state
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  updated_ff, updated_in;
   logic                  running_ff, running_in;
   mtc_pkg::mtc_time_type cur_time_ff, cur_time_in;
   logic [26:0]           head_ff, head_in;

   logic                       req_take;
   logic                       in_advance;
   logic                       qf_fire;
   logic                       full_frame_ok;
   mtc_pkg::mtc_time_type      full_time;
   mtc_pkg::mtc_qf_result_type qf_result;
   logic [26:0]                head_calc;

   // flow control: the input register moves on when the result slot is
   // empty or being taken in this cycle
   assign in_advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign qf_fire = in_advance && (status_ff == mtc_pkg::STATUS_QUARTER_FRAME);

   mtc_quarter u_quarter (
      .clock        (clock),
      .reset        (reset),
      .qf_fire      (qf_fire),
      .qf_data      (b1_ff),
      .frame_adjust (frame_adjust_ff),
      .qf_result    (qf_result)
   );

   // full-frame sysex: F0 7F 7F 01 01 hh mm ss ff F7
   always_comb begin
      full_frame_ok = (status_ff == mtc_pkg::STATUS_SYSEX) &&
                      (length_ff == mtc_pkg::FULL_FRAME_LENGTH) &&
                      (b1_ff == mtc_pkg::SYSEX_UNIVERSAL) &&
                      (b2_ff == mtc_pkg::SYSEX_ALL_DEVICES) &&
                      (b3_ff == mtc_pkg::SYSEX_SUB_ID_MTC) &&
                      (b4_ff == mtc_pkg::SYSEX_FULL_FRAME) &&
                      (b9_ff == mtc_pkg::SYSEX_END);
      full_time.hours   = b5_ff[4:0];
      full_time.rate    = b5_ff[6:5];
      full_time.minutes = b6_ff[6:0];
      full_time.seconds = b7_ff[6:0];
      full_time.frames  = b8_ff[6:0];
   end

   always_comb begin
      if (qf_result.done) begin
         cur_time_in = qf_result.tc;
      end else if (full_frame_ok) begin
         cur_time_in = full_time;
      end else begin
         cur_time_in = cur_time_ff;
      end
   end

   mtc_head u_head (
      .tc      (cur_time_in),
      .head_ms (head_calc)
   );

   always_comb begin
      updated_in = qf_result.done || full_frame_ok;
      running_in = (gap_ff <= gap_limit_ff);
      head_in    = updated_in ? head_calc : head_ff;
      if (in_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff    <= mtc_pkg::GAP_LIMIT_RESET;
         frame_adjust_ff <= mtc_pkg::FRAME_ADJUST_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mtc_pkg::CSR_GAP_LIMIT:    gap_limit_ff    <= csr_data;
            mtc_pkg::CSR_FRAME_ADJUST: frame_adjust_ff <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         status_ff <= req_status_byte;
         length_ff <= req_msg_length;
         b1_ff     <= req_byte_one;
         b2_ff     <= req_byte_two;
         b3_ff     <= req_byte_three;
         b4_ff     <= req_byte_four;
         b5_ff     <= req_byte_five;
         b6_ff     <= req_byte_six;
         b7_ff     <= req_byte_seven;
         b8_ff     <= req_byte_eight;
         b9_ff     <= req_byte_nine;
         gap_ff    <= req_gap_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff        <= 1'b0;
         cur_time_ff.hours   <= '0;
         cur_time_ff.minutes <= '0;
         cur_time_ff.seconds <= '0;
         cur_time_ff.frames  <= '0;
         cur_time_ff.rate    <= mtc_pkg::RATE_RESET;
         head_ff             <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_advance) begin
            cur_time_ff <= cur_time_in;
            head_ff     <= head_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         updated_ff <= updated_in;
         running_ff <= running_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_time_updated = updated_ff;
   assign rsp_code_running = running_ff;
   assign rsp_out_hours    = cur_time_ff.hours;
   assign rsp_out_minutes  = cur_time_ff.minutes;
   assign rsp_out_seconds  = cur_time_ff.seconds;
   assign rsp_out_frames   = cur_time_ff.frames;
   assign rsp_out_rate     = cur_time_ff.rate;
   assign rsp_head_ms      = head_ff;

endmodule

/* src/mtc_quarter.sv */
// ----------------------------------------------------------------------------
// mtc_quarter: quarter-frame gathering
// Collects the eight pieces, learns the direction of travel and flags completion.
// ----------------------------------------------------------------------------
module mtc_quarter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       qf_fire,
   input  logic [7:0]                 qf_data,
   input  logic [1:0]                 frame_adjust,
   output mtc_pkg::mtc_qf_result_type qf_result
);

   logic [4:0]       hours_ff, hours_in;
   logic [5:0]       minutes_ff, minutes_in;
   logic [5:0]       seconds_ff, seconds_in;
   logic [4:0]       frames_ff, frames_in;
   logic [1:0]       rate_ff, rate_in;
   logic [3:0]       count_ff, count_in;
   mtc_pkg::dir_type dir_ff, dir_in;
   logic [7:0]       prev_ff, prev_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;

   logic [3:0] kind;
   logic [3:0] prev_kind;
   logic [3:0] count_sat;
   logic       done;

   always_comb begin
      kind      = qf_data[7:4];
      prev_kind = prev_ff[7:4];
      count_sat = (count_ff == mtc_pkg::PIECE_COUNT_MAX) ? count_ff : count_ff + 4'd1;

      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      frames_in  = frames_ff;
      rate_in    = rate_ff;
      count_in   = count_ff;
      dir_in     = dir_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      done       = 1'b0;

      if (qf_fire) begin
         if (dir_ff == mtc_pkg::DIR_UNKNOWN && count_ff > 4'd1) begin
            if (prev_kind < kind) begin
               dir_in = mtc_pkg::DIR_FORWARD;
            end else if (prev_kind > kind) begin
               dir_in = mtc_pkg::DIR_BACKWARD;
            end
         end
         prev_in = qf_data;

         // pieces 8..F only move direction and previous byte
         case (kind)
            mtc_pkg::PIECE_FRAMES_LO: begin
               frames_in = {1'b0, qf_data[3:0]};
               count_in  = count_sat;
               first_in  = 1'b1;
               done      = (count_sat >= mtc_pkg::PIECES_PER_CODE) &&
                           (dir_in == mtc_pkg::DIR_BACKWARD) && last_ff;
            end
            mtc_pkg::PIECE_FRAMES_HI: begin
               frames_in = frames_ff | {qf_data[0], 4'b0000};
               count_in  = count_sat;
            end
            mtc_pkg::PIECE_SECONDS_LO: begin
               seconds_in = {2'b00, qf_data[3:0]};
               count_in   = count_sat;
            end
            mtc_pkg::PIECE_SECONDS_HI: begin
               seconds_in = seconds_ff | {qf_data[1:0], 4'b0000};
               count_in   = count_sat;
            end
            mtc_pkg::PIECE_MINUTES_LO: begin
               minutes_in = {2'b00, qf_data[3:0]};
               count_in   = count_sat;
            end
            mtc_pkg::PIECE_MINUTES_HI: begin
               minutes_in = minutes_ff | {qf_data[1:0], 4'b0000};
               count_in   = count_sat;
            end
            mtc_pkg::PIECE_HOURS_LO: begin
               hours_in = {1'b0, qf_data[3:0]};
               count_in = count_sat;
            end
            mtc_pkg::PIECE_HOURS_HI: begin
               hours_in = hours_ff | {qf_data[0], 4'b0000};
               rate_in  = qf_data[2:1];
               count_in = count_sat;
               last_in  = 1'b1;
               done     = (count_sat >= mtc_pkg::PIECES_PER_CODE) &&
                          (dir_in == mtc_pkg::DIR_FORWARD) && first_ff;
            end
            default: begin
            end
         endcase
      end

      // completed code, frames include the delay adjustment (not wrapped)
      qf_result.done       = done;
      qf_result.tc.hours   = hours_in;
      qf_result.tc.minutes = {1'b0, minutes_in};
      qf_result.tc.seconds = {1'b0, seconds_in};
      qf_result.tc.frames  = {2'b00, frames_in} + {5'b00000, frame_adjust};
      qf_result.tc.rate    = rate_in;

      if (done) begin
         hours_in   = '0;
         minutes_in = '0;
         seconds_in = '0;
         frames_in  = '0;
         rate_in    = '0;
         count_in   = '0;
         dir_in     = mtc_pkg::DIR_UNKNOWN;
         first_in   = 1'b0;
         last_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         frames_ff  <= '0;
         rate_ff    <= '0;
         count_ff   <= '0;
         dir_ff     <= mtc_pkg::DIR_UNKNOWN;
         prev_ff    <= '0;
         first_ff   <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         frames_ff  <= frames_in;
         rate_ff    <= rate_in;
         count_ff   <= count_in;
         dir_ff     <= dir_in;
         prev_ff    <= prev_in;
         first_ff   <= first_in;
         last_ff    <= last_in;
      end
   end

endmodule

/* src/mtc_head.sv */
// ----------------------------------------------------------------------------
// mtc_head: time code to head position
// Whole milliseconds from hours, minutes, seconds, frames and frame rate.
// ----------------------------------------------------------------------------
module mtc_head (
   input  mtc_pkg::mtc_time_type tc,
   output logic [26:0]           head_ms
);

   logic [26:0] hour_part;
   logic [26:0] minute_part;
   logic [26:0] second_part;
   logic [36:0] frame_product;
   logic [12:0] frame_part;

   always_comb begin
      hour_part     = {22'd0, tc.hours} * mtc_pkg::HOUR_MS;
      minute_part   = {20'd0, tc.minutes} * mtc_pkg::MINUTE_MS;
      second_part   = {20'd0, tc.seconds} * mtc_pkg::SECOND_MS;
      // truncating division by the frame rate via fixed-point reciprocal
      frame_product = {30'd0, tc.frames} * {7'd0, mtc_pkg::FRAME_MS_K[tc.rate]};
      frame_part    = frame_product[mtc_pkg::FRAME_MS_SHIFT +: 13];
      head_ms       = hour_part + minute_part + second_part + {14'd0, frame_part};
   end

endmodule

/* tb/midi_timecode_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_timecode_decoder_unit_tb: self-checking bench for the MIDI time code decoder
// Drives quarter-frame runs, full-frame sysex and stray messages with random
// gaps and output stalls, predicts every readout and checks it field by field.
// ----------------------------------------------------------------------------
module midi_timecode_decoder_unit_tb;

   // Frame rate codes carried in the time code
   localparam logic [1:0] RATE_24FPS   = 2'd0;
   localparam logic [1:0] RATE_25FPS   = 2'd1;
   localparam logic [1:0] RATE_2997FPS = 2'd2;
   localparam logic [1:0] RATE_30FPS   = 2'd3;

   // Status bytes the decoder must ignore
   localparam logic [7:0] STATUS_NOTE_ON      = 8'h90;
   localparam logic [7:0] STATUS_TIMING_CLOCK = 8'hF8;

   localparam int unsigned RANDOM_PER_PHASE = 225;
   localparam int unsigned MAX_REPORTS      = 10;
   // Result passes the input and result registers; leave slack for stalls.
   localparam int unsigned DRAIN_CYCLES     = 16;
   localparam int unsigned LONG_HOLD        = 80;

   typedef struct packed {
      logic [7:0]  status_byte;
      logic [7:0]  msg_length;
      logic [7:0]  byte_one;
      logic [7:0]  byte_two;
      logic [7:0]  byte_three;
      logic [7:0]  byte_four;
      logic [7:0]  byte_five;
      logic [7:0]  byte_six;
      logic [7:0]  byte_seven;
      logic [7:0]  byte_eight;
      logic [7:0]  byte_nine;
      logic [15:0] gap_ms;
   } midi_msg_type;

   typedef struct packed {
      logic        updated;
      logic        running;
      logic [4:0]  hours;
      logic [6:0]  minutes;
      logic [6:0]  seconds;
      logic [6:0]  frames;
      logic [1:0]  rate;
      logic [26:0] head;
   } readout_type;

   // DUT connections; every input starts at a known value
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_time_updated;
   logic        rsp_code_running;
   logic [4:0]  rsp_out_hours;
   logic [6:0]  rsp_out_minutes;
   logic [6:0]  rsp_out_seconds;
   logic [6:0]  rsp_out_frames;
   logic [1:0]  rsp_out_rate;
   logic [26:0] rsp_head_ms;
   midi_msg_type offered = '0;

   // Message backlog (filled by the stimulus block) and predicted readouts
   midi_msg_type midi_backlog [$];
   readout_type  decoder_readouts [$];
   int unsigned  msgs_taken = 0;
   int unsigned  readouts_checked = 0;
   int unsigned  planned_msgs = 0;
   int unsigned  mismatch_count = 0;

   // Idling control
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   logic        send_calm = 1'b0;
   logic        recv_calm = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned next_hold_at = 150;

   // Predictor copy of the registers
   logic [15:0] cfg_gap_limit;
   logic [1:0]  cfg_frame_adjust;

   // Predictor copy of the gathering state
   logic [4:0]       gath_hours;
   logic [5:0]       gath_minutes;
   logic [5:0]       gath_seconds;
   logic [4:0]       gath_frames;
   logic [1:0]       gath_rate;
   logic [3:0]       piece_total;
   mtc_pkg::dir_type travel;
   logic [7:0]       last_piece_byte;
   logic             got_first;
   logic             got_last;

   // Predictor copy of the latched time
   logic [4:0]  tc_hours;
   logic [6:0]  tc_minutes;
   logic [6:0]  tc_seconds;
   logic [6:0]  tc_frames;
   logic [1:0]  tc_rate;
   logic [26:0] tc_head;

   midi_timecode_decoder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_status_byte  (offered.status_byte),
      .req_msg_length   (offered.msg_length),
      .req_byte_one     (offered.byte_one),
      .req_byte_two     (offered.byte_two),
      .req_byte_three   (offered.byte_three),
      .req_byte_four    (offered.byte_four),
      .req_byte_five    (offered.byte_five),
      .req_byte_six     (offered.byte_six),
      .req_byte_seven   (offered.byte_seven),
      .req_byte_eight   (offered.byte_eight),
      .req_byte_nine    (offered.byte_nine),
      .req_gap_ms       (offered.gap_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_time_updated (rsp_time_updated),
      .rsp_code_running (rsp_code_running),
      .rsp_out_hours    (rsp_out_hours),
      .rsp_out_minutes  (rsp_out_minutes),
      .rsp_out_seconds  (rsp_out_seconds),
      .rsp_out_frames   (rsp_out_frames),
      .rsp_out_rate     (rsp_out_rate),
      .rsp_head_ms      (rsp_head_ms)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Truncated head position of the latched time in ms
   function automatic logic [26:0] head_position();
      int unsigned whole_s;
      int unsigned frame_ms;
      whole_s = tc_hours * 3600 + tc_minutes * 60 + tc_seconds;
      case (tc_rate)
         RATE_24FPS:   frame_ms = tc_frames * 1000 / 24;
         RATE_25FPS:   frame_ms = tc_frames * 1000 / 25;
         RATE_2997FPS: frame_ms = tc_frames * 100000 / 2997;
         default:      frame_ms = tc_frames * 1000 / 30;
      endcase
      return 27'(whole_s * 1000 + frame_ms);
   endfunction

   function automatic void clear_gathering();
      gath_hours   = '0;
      gath_minutes = '0;
      gath_seconds = '0;
      gath_frames  = '0;
      gath_rate    = '0;
      piece_total  = '0;
      travel       = mtc_pkg::DIR_UNKNOWN;
      got_first    = 1'b0;
      got_last     = 1'b0;
   endfunction

   // Advances the predictor by one message and returns its readout
   function automatic readout_type decode_message(midi_msg_type m);
      readout_type r;
      logic [3:0]  kind;
      logic [3:0]  last_kind;
      logic        done;
      done      = 1'b0;
      kind      = m.byte_one[7:4];
      last_kind = last_piece_byte[7:4];
      if (m.status_byte == mtc_pkg::STATUS_QUARTER_FRAME) begin
         // direction is learned once two pieces have been seen
         if (travel == mtc_pkg::DIR_UNKNOWN && piece_total > 4'd1) begin
            if (last_kind < kind)
               travel = mtc_pkg::DIR_FORWARD;
            else if (last_kind > kind)
               travel = mtc_pkg::DIR_BACKWARD;
         end
         last_piece_byte = m.byte_one;
         // pieces 8..F only steer the direction
         if (kind <= mtc_pkg::PIECE_HOURS_HI) begin
            if (piece_total != mtc_pkg::PIECE_COUNT_MAX)
               piece_total++;
            case (kind)
               mtc_pkg::PIECE_FRAMES_LO: begin
                  gath_frames = {1'b0, m.byte_one[3:0]};
                  got_first   = 1'b1;
                  done = piece_total >= mtc_pkg::PIECES_PER_CODE &&
                         travel == mtc_pkg::DIR_BACKWARD && got_last;
               end
               mtc_pkg::PIECE_FRAMES_HI:
                  gath_frames[4] = gath_frames[4] | m.byte_one[0];
               mtc_pkg::PIECE_SECONDS_LO:
                  gath_seconds = {2'b00, m.byte_one[3:0]};
               mtc_pkg::PIECE_SECONDS_HI:
                  gath_seconds[5:4] = gath_seconds[5:4] | m.byte_one[1:0];
               mtc_pkg::PIECE_MINUTES_LO:
                  gath_minutes = {2'b00, m.byte_one[3:0]};
               mtc_pkg::PIECE_MINUTES_HI:
                  gath_minutes[5:4] = gath_minutes[5:4] | m.byte_one[1:0];
               mtc_pkg::PIECE_HOURS_LO:
                  gath_hours = {1'b0, m.byte_one[3:0]};
               default: begin
                  gath_hours[4] = gath_hours[4] | m.byte_one[0];
                  gath_rate     = m.byte_one[2:1];
                  got_last      = 1'b1;
                  done = piece_total >= mtc_pkg::PIECES_PER_CODE &&
                         travel == mtc_pkg::DIR_FORWARD && got_first;
               end
            endcase
         end
         if (done) begin
            // frame adjust is not wrapped at the frame count
            tc_frames  = 7'(gath_frames) + 7'(cfg_frame_adjust);
            tc_hours   = gath_hours;
            tc_minutes = 7'(gath_minutes);
            tc_seconds = 7'(gath_seconds);
            tc_rate    = gath_rate;
            tc_head    = head_position();
            clear_gathering();
         end
      end else if (m.status_byte == mtc_pkg::STATUS_SYSEX &&
                   m.msg_length == mtc_pkg::FULL_FRAME_LENGTH &&
                   m.byte_one == mtc_pkg::SYSEX_UNIVERSAL &&
                   m.byte_two == mtc_pkg::SYSEX_ALL_DEVICES &&
                   m.byte_three == mtc_pkg::SYSEX_SUB_ID_MTC &&
                   m.byte_four == mtc_pkg::SYSEX_FULL_FRAME &&
                   m.byte_nine == mtc_pkg::SYSEX_END) begin
         tc_hours   = m.byte_five[4:0];
         tc_rate    = m.byte_five[6:5];
         tc_minutes = m.byte_six[6:0];
         tc_seconds = m.byte_seven[6:0];
         tc_frames  = m.byte_eight[6:0];
         tc_head    = head_position();
         done       = 1'b1;
      end
      r.updated = done;
      r.running = m.gap_ms <= cfg_gap_limit;
      r.hours   = tc_hours;
      r.minutes = tc_minutes;
      r.seconds = tc_seconds;
      r.frames  = tc_frames;
      r.rate    = tc_rate;
      r.head    = tc_head;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Message generation
   // ------------------------------------------------------------------

   // Gaps cluster around the running limit so both outcomes show up
   function automatic logic [15:0] pick_gap();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return cfg_gap_limit;
         3:       return cfg_gap_limit + 16'd1;
         4:       return cfg_gap_limit - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic midi_msg_type random_msg();
      midi_msg_type m;
      m = 104'({$urandom, $urandom, $urandom, $urandom});
      m.gap_ms = pick_gap();
      return m;
   endfunction

   function automatic midi_msg_type quarter_msg(logic [7:0] data);
      midi_msg_type m;
      m = random_msg();
      m.status_byte = mtc_pkg::STATUS_QUARTER_FRAME;
      m.byte_one    = data;
      return m;
   endfunction

   function automatic midi_msg_type full_frame_msg(logic [7:0] hr_rate, logic [7:0] mins,
                                                   logic [7:0] secs, logic [7:0] frms);
      midi_msg_type m;
      m = random_msg();
      m.status_byte = mtc_pkg::STATUS_SYSEX;
      m.msg_length  = mtc_pkg::FULL_FRAME_LENGTH;
      m.byte_one    = mtc_pkg::SYSEX_UNIVERSAL;
      m.byte_two    = mtc_pkg::SYSEX_ALL_DEVICES;
      m.byte_three  = mtc_pkg::SYSEX_SUB_ID_MTC;
      m.byte_four   = mtc_pkg::SYSEX_FULL_FRAME;
      m.byte_five   = hr_rate;
      m.byte_six    = mins;
      m.byte_seven  = secs;
      m.byte_eight  = frms;
      m.byte_nine   = mtc_pkg::SYSEX_END;
      return m;
   endfunction

   function automatic void enqueue(midi_msg_type m, logic counted);
      midi_backlog.push_back(m);
      if (counted)
         planned_msgs++;
   endfunction

   // A run of quarter frames: mostly in order, forward or backward, with the
   // odd dropped piece, invalid piece or stray status mixed in
   function automatic void add_piece_run();
      logic [2:0]   piece;
      int unsigned  order;
      int unsigned  run_len;
      midi_msg_type m;
      piece   = 3'($urandom);
      order   = $urandom_range(0, 5);
      run_len = $urandom_range(8, 20);
      repeat (run_len) begin
         m = quarter_msg({1'b0, piece, 4'($urandom)});
         case ($urandom_range(0, 24))
            0:       m.byte_one[7] = 1'b1;
            1:       m.status_byte = 8'($urandom);
            default: ;
         endcase
         enqueue(m, 1'b1);
         if (order <= 2)
            piece = piece + 3'd1;
         else if (order <= 4)
            piece = piece - 3'd1;
         else
            piece = 3'($urandom);
         if ($urandom_range(0, 29) == 0)
            piece = 3'($urandom);
      end
   endfunction

   // Full frame, sometimes with one framing byte broken
   function automatic void add_full_frame();
      midi_msg_type m;
      m = full_frame_msg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      case ($urandom_range(0, 9))
         0:       m.msg_length = 8'($urandom);
         1:       m.byte_one   = 8'($urandom);
         2:       m.byte_two   = 8'($urandom);
         3:       m.byte_three = 8'($urandom);
         4:       m.byte_four  = 8'($urandom);
         5:       m.byte_nine  = 8'($urandom);
         default: ;
      endcase
      enqueue(m, 1'b1);
   endfunction

   function automatic int unsigned draw_wait(logic calm);
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers backlog messages on the req_ channel. The payload only
   // moves on once the current message has transferred, and a drawn gap
   // (valid low) follows each transfer.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : message_driver
      if (reset) begin
         req_valid  <= 1'b0;
         send_wait  <= 0;
         msgs_taken <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            decoder_readouts.push_back(decode_message(offered));
            msgs_taken <= msgs_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait != 0) begin
               req_valid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (midi_backlog.size() != 0) begin
               offered   <= midi_backlog.pop_front();
               req_valid <= 1'b1;
               // keep pushing during a long receiver hold so the unit backs up
               send_wait <= (hold_cycles != 0) ? 0 : draw_wait(send_calm);
               if ($urandom_range(0, 39) == 0)
                  send_calm <= !send_calm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started every 400 messages or so
   always @(posedge clock) begin : hold_timer
      if (reset) begin
         hold_cycles  <= 0;
         next_hold_at <= 150;
      end else if (msgs_taken >= next_hold_at) begin
         hold_cycles  <= LONG_HOLD;
         next_hold_at <= next_hold_at + 400;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("readout %0d %s: expected %0d, got %0d", readouts_checked, field, want,
                     got);
      end
   endfunction

   // ------------------------------------------------------------------
   // Monitor: checks each rsp_ transfer against the oldest prediction and
   // draws its own stall after each transfer outside a long hold. Message and
   // readout counters use nonblocking writes: both blocks see pre-edge values.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      readout_type want;
      int unsigned pause;
      if (reset) begin
         rsp_stall        <= 1'b0;
         recv_wait        <= 0;
         readouts_checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (readouts_checked == msgs_taken) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("readout transfer with no message outstanding");
            end else begin
               want = decoder_readouts.pop_front();
               compare_field("time_updated", 32'(want.updated), 32'(rsp_time_updated));
               compare_field("code_running", 32'(want.running), 32'(rsp_code_running));
               compare_field("out_hours", 32'(want.hours), 32'(rsp_out_hours));
               compare_field("out_minutes", 32'(want.minutes), 32'(rsp_out_minutes));
               compare_field("out_seconds", 32'(want.seconds), 32'(rsp_out_seconds));
               compare_field("out_frames", 32'(want.frames), 32'(rsp_out_frames));
               compare_field("out_rate", 32'(want.rate), 32'(rsp_out_rate));
               compare_field("head_ms", 32'(want.head), 32'(rsp_head_ms));
               readouts_checked <= readouts_checked + 1;
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm <= !recv_calm;
         end
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            pause = draw_wait(recv_calm);
            rsp_stall <= (pause != 0);
            recv_wait <= (pause != 0) ? pause - 1 : 0;
         end else if (recv_wait != 0) begin
            rsp_stall <= 1'b1;
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus: the backlog is filled and checked at the falling edge so it
   // never races the clocked driver and monitor.
   // ------------------------------------------------------------------

   // Waits until every message has transferred and every readout is back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (midi_backlog.size() != 0 || req_valid || msgs_taken != readouts_checked);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == mtc_pkg::CSR_GAP_LIMIT)
         cfg_gap_limit = value;
      else
         cfg_frame_adjust = value[1:0];
   endtask

   initial begin : stimulus
      logic [15:0]  phase_gap [5];
      logic [1:0]   phase_adjust [5];
      midi_msg_type m;

      // predictor state after reset
      cfg_gap_limit    = mtc_pkg::GAP_LIMIT_RESET;
      cfg_frame_adjust = mtc_pkg::FRAME_ADJUST_RESET;
      clear_gathering();
      last_piece_byte  = '0;
      tc_hours         = '0;
      tc_minutes       = '0;
      tc_seconds       = '0;
      tc_frames        = '0;
      tc_rate          = mtc_pkg::RATE_RESET;
      tc_head          = '0;

      // extremes of both registers, plus random settings
      phase_gap    = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom)};
      phase_adjust = '{2'd0, 2'd3, 2'd1, 2'($urandom), 2'd2};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, under the reset register values.
      m = '0;                                    // all-zero message, zero gap
      enqueue(m, 1'b1);
      m = '1;                                    // all-ones, longest gap
      enqueue(m, 1'b1);
      m = random_msg();                          // gap equal to the limit still runs
      m.status_byte = STATUS_NOTE_ON;
      m.gap_ms      = mtc_pkg::GAP_LIMIT_RESET;
      enqueue(m, 1'b1);
      m = random_msg();                          // one past the limit stops
      m.status_byte = STATUS_TIMING_CLOCK;
      m.gap_ms      = mtc_pkg::GAP_LIMIT_RESET + 16'd1;
      enqueue(m, 1'b1);
      // full frames: every field at max (hours 31, 30 fps), 29.97 fps, 24 fps
      enqueue(full_frame_msg(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
      enqueue(full_frame_msg({1'b0, RATE_2997FPS, 5'd23}, 8'd59, 8'd59, 8'd29), 1'b1);
      enqueue(full_frame_msg({1'b0, RATE_24FPS, 5'd0}, 8'd0, 8'd0, 8'd23), 1'b1);
      // short length and a missing end byte are not full frames
      m = full_frame_msg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      m.msg_length = mtc_pkg::FULL_FRAME_LENGTH - 8'd1;
      enqueue(m, 1'b1);
      m = full_frame_msg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      m.byte_nine = mtc_pkg::STATUS_SYSEX;
      enqueue(m, 1'b1);
      // forward run with all-ones nibbles completes at piece 7
      for (int p = 0; p < 8; p++)
         enqueue(quarter_msg({1'b0, 3'(p), 4'hF}), 1'b1);
      // backward run with zero nibbles completes at piece 0
      for (int p = 7; p >= 0; p--)
         enqueue(quarter_msg({1'b0, 3'(p), 4'h0}), 1'b1);
      // invalid piece number
      enqueue(quarter_msg(8'hF5), 1'b1);
      wait_drained();

      // Random phases, one register setting each
      for (int ph = 0; ph < 5; ph++) begin
         write_register(mtc_pkg::CSR_GAP_LIMIT, phase_gap[ph]);
         write_register(mtc_pkg::CSR_FRAME_ADJUST, {14'($urandom), phase_adjust[ph]});
         @(negedge clock);
         planned_msgs = 0;
         while (planned_msgs < RANDOM_PER_PHASE) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: add_piece_run();
               6, 7:             add_full_frame();
               default:          enqueue(random_msg(), 1'b0);
            endcase
         end
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("timeout waiting for the decoder");
      $display("Mismatches found");
      $finish;
   end

endmodule
